FILE: hdl/cmf2d_pkg.sv
`default_nettype none

package cmf2d_pkg;

  localparam int DEF_MAX_HALF   = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int RESET_HALF   = 1;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_HALF   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  typedef struct packed {
    logic   valid;
    logic   emit;
    logic   inner;
    logic   last;
    pixel_t pass;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/cmf2d_line_buf.sv
`default_nettype none

module cmf2d_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  cmf2d_pkg::pixel_t       wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output cmf2d_pkg::pixel_t       qa,
  output cmf2d_pkg::pixel_t       qb
);
  import cmf2d_pkg::*;

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      qa <= mem[raddr_a];
      qb <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cmf2d_sort_cell.sv
`default_nettype none

module cmf2d_sort_cell #(
  parameter int NUM   = 49,
  parameter int PHASE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cmf2d_pkg::ctrl_t  d_ctrl,
  input  cmf2d_pkg::pixel_t d_vals [NUM],
  output cmf2d_pkg::ctrl_t  q_ctrl,
  output cmf2d_pkg::pixel_t q_vals [NUM]
);
  import cmf2d_pkg::*;

  pixel_t xv [NUM];

  // one odd/even transposition step, each channel on its own
  always_comb begin
    xv = d_vals;
    for (int i = PHASE; i + 1 < NUM; i += 2) begin
      if (d_vals[i].b > d_vals[i+1].b) begin
        xv[i].b   = d_vals[i+1].b;
        xv[i+1].b = d_vals[i].b;
      end
      if (d_vals[i].g > d_vals[i+1].g) begin
        xv[i].g   = d_vals[i+1].g;
        xv[i+1].g = d_vals[i].g;
      end
      if (d_vals[i].r > d_vals[i+1].r) begin
        xv[i].r   = d_vals[i+1].r;
        xv[i+1].r = d_vals[i].r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ctrl.valid <= 1'b0;
    end else if (en) begin
      q_ctrl <= d_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_vals <= xv;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/color_median_filter_2d_unit.sv
`default_nettype none

// channel  ports                           role
// s_*      s_tvalid s_tready s_tdata s_tuser  pixels and flush ticks in
// m_*      m_tvalid m_tready m_tdata m_tuser  one result per accepted transfer
//          m_tlast
// cfg_*    cfg_we cfg_addr cfg_data           register writes, no read-back
//
// One transfer per clock unless m_tready stalls; results pass the window stage, the
// odd/even transposition chain of one cell per window element, then the output register.
// Line store: 2*MAX_HALF+1 row banks, one write and two reads per cycle each.
// A stall on m_tready freezes the whole pipeline and drops s_tready.
// Synchronous reset clears counters and valid bits; line store is not cleared.

module color_median_filter_2d_unit #(
  parameter int MAX_HALF   = cmf2d_pkg::DEF_MAX_HALF,
  parameter int MAX_WIDTH  = cmf2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cmf2d_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // blue_in, green_in, red_in
  input  logic                             s_tuser,   // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,   // blue_out, green_out, red_out
  output logic                             m_tuser,   // out_valid
  output logic                             m_tlast,   // frame_last
  input  logic                             cfg_we,
  input  logic [cmf2d_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cmf2d_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cmf2d_pkg::*;

  localparam int KMAX = 2 * MAX_HALF + 1;
  localparam int N    = KMAX * KMAX;
  localparam int MID  = N / 2;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int HH   = $clog2(MAX_HALF + 1);
  localparam int RW   = $clog2(KMAX);
  localparam int GW   = $clog2(MAX_HALF * MAX_WIDTH + MAX_HALF + 2);

  localparam int RST_H = (RESET_HALF > MAX_HALF) ? MAX_HALF : RESET_HALF;
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_T = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
  localparam int RST_D = RST_H * RST_W + RST_H;

  // configuration
  logic [HH-1:0] half;
  logic [WW-1:0] width;
  logic [HW-1:0] height;
  logic [GW-1:0] delay;

  logic [HH-1:0] h_cfg, h_sel;
  logic [WW-1:0] w_cfg, w_sel;
  logic [HW-1:0] t_cfg;
  logic [GW-1:0] delay_cfg;
  logic          cfg_hit;

  always_comb begin
    h_cfg = (cfg_data[1:0] > MAX_HALF) ? HH'(MAX_HALF) : HH'(cfg_data[1:0]);
    if (cfg_data == '0) begin
      w_cfg = WW'(1);
      t_cfg = HW'(1);
    end else begin
      w_cfg = (32'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
      t_cfg = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
    end
    h_sel = (cfg_addr == REG_HALF) ? h_cfg : half;
    w_sel = (cfg_addr == REG_WIDTH) ? w_cfg : width;
    delay_cfg = GW'(int'(h_sel) * int'(w_sel) + int'(h_sel));
    cfg_hit = cfg_we && (cfg_addr == REG_HALF || cfg_addr == REG_WIDTH ||
                         cfg_addr == REG_HEIGHT);
  end

  // input side control
  logic          adv, accept, wr, frame_done, done_after, emit, last, inner, byp;
  logic [HW-1:0] in_row, oi;
  logic [AW-1:0] in_col, oj;
  logic [RW-1:0] in_ring, o_ring;
  logic [GW-1:0] gap, gap_adv;
  pixel_t        pix_in;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign pix_in   = pixel_t'(s_tdata);

  always_comb begin
    frame_done = (in_row == height);
    wr         = accept && !s_tuser && !frame_done;
    done_after = frame_done ||
                 (wr && WW'(in_col) == width - 1'b1 && in_row == height - 1'b1);
    gap_adv    = gap + GW'(wr);
    emit       = accept && (done_after || gap_adv > delay);
    last       = emit && WW'(oj) == width - 1'b1 && oi == height - 1'b1;
    inner      = emit && half != '0 && oi >= HW'(half) && oj >= AW'(half) &&
                 ((HW+1)'(oi) + (HW+1)'(half) < (HW+1)'(height)) &&
                 ((WW+1)'(oj) + (WW+1)'(half) < (WW+1)'(width));
    byp        = wr && in_ring == o_ring && in_col == oj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half    <= HH'(RST_H);
      width   <= WW'(RST_W);
      height  <= HW'(RST_T);
      delay   <= GW'(RST_D);
      in_row  <= '0;
      in_col  <= '0;
      in_ring <= '0;
      oi      <= '0;
      oj      <= '0;
      o_ring  <= '0;
      gap     <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_addr)
        REG_HALF:   half   <= h_cfg;
        REG_WIDTH:  width  <= w_cfg;
        REG_HEIGHT: height <= t_cfg;
        default:    ;
      endcase
      delay   <= delay_cfg;
      in_row  <= '0;
      in_col  <= '0;
      in_ring <= '0;
      oi      <= '0;
      oj      <= '0;
      o_ring  <= '0;
      gap     <= '0;
    end else if (accept) begin
      if (last) begin
        in_row  <= '0;
        in_col  <= '0;
        in_ring <= '0;
        oi      <= '0;
        oj      <= '0;
        o_ring  <= '0;
        gap     <= '0;
      end else begin
        if (wr) begin
          if (WW'(in_col) == width - 1'b1) begin
            in_col  <= '0;
            in_row  <= in_row + 1'b1;
            in_ring <= (in_ring == RW'(KMAX - 1)) ? '0 : in_ring + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
        end
        if (emit) begin
          if (WW'(oj) == width - 1'b1) begin
            oj     <= '0;
            oi     <= oi + 1'b1;
            o_ring <= (o_ring == RW'(KMAX - 1)) ? '0 : o_ring + 1'b1;
          end else begin
            oj <= oj + 1'b1;
          end
        end
        gap <= gap_adv - GW'(emit);
      end
    end
  end

  // line store, one bank per ring row
  pixel_t qa [KMAX];
  pixel_t qb [KMAX];

  for (genvar bk = 0; bk < KMAX; bk++) begin : g_bank
    cmf2d_line_buf #(
      .DEPTH(MAX_WIDTH)
    ) u_buf (
      .clk    (clk),
      .en     (adv),
      .we     (wr && in_ring == RW'(bk)),
      .waddr  (in_col),
      .wdata  (pix_in),
      .raddr_a(in_col),
      .raddr_b(oj),
      .qa     (qa[bk]),
      .qb     (qb[bk])
    );
  end

  // window stage
  logic          b_valid, b_shift, b_emit, b_inner, b_last, b_byp;
  pixel_t        b_pix;
  logic [RW-1:0] b_ring, b_oring;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_shift <= wr;
      b_emit  <= emit;
      b_inner <= inner;
      b_last  <= last;
      b_byp   <= byp;
      b_pix   <= pix_in;
      b_ring  <= in_ring;
      b_oring <= o_ring;
    end
  end

  pixel_t win      [KMAX][KMAX];
  pixel_t win_next [KMAX][KMAX];
  pixel_t newcol   [KMAX];
  pixel_t vals0    [N];
  ctrl_t  ctrl0;

  always_comb begin
    int t;
    newcol[KMAX-1] = b_pix;
    for (int d = 1; d < KMAX; d++) begin
      t = int'(b_ring) + KMAX - d;
      if (t >= KMAX) begin
        t = t - KMAX;
      end
      newcol[KMAX-1-d] = qa[RW'(t)];
    end
  end

  always_comb begin
    win_next = win;
    if (b_valid && b_shift) begin
      for (int rr = 0; rr < KMAX; rr++) begin
        for (int cc = 0; cc < KMAX - 1; cc++) begin
          win_next[rr][cc] = win[rr][cc+1];
        end
        win_next[rr][KMAX-1] = newcol[rr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win <= win_next;
    end
  end

  // unused border of the window: half zeros, half full scale, median stays central
  always_comb begin
    int ah;
    int a;
    ah = MAX_HALF - int'(half);
    a  = 2 * ah;
    for (int rr = 0; rr < KMAX; rr++) begin
      for (int cc = 0; cc < KMAX; cc++) begin
        if (rr >= a && cc >= a) begin
          vals0[rr*KMAX+cc] = win_next[rr][cc];
        end else if (rr < a) begin
          vals0[rr*KMAX+cc] = (rr < ah) ? '0 : '1;
        end else begin
          vals0[rr*KMAX+cc] = (cc < ah) ? '0 : '1;
        end
      end
    end
    ctrl0.valid = b_valid;
    ctrl0.emit  = b_emit;
    ctrl0.inner = b_inner;
    ctrl0.last  = b_last;
    ctrl0.pass  = b_byp ? b_pix : qb[b_oring];
  end

  // sorting chain
  ctrl_t  cctl [N+1];
  pixel_t cval [N+1][N];

  assign cctl[0] = ctrl0;
  assign cval[0] = vals0;

  for (genvar s = 0; s < N; s++) begin : g_cell
    cmf2d_sort_cell #(
      .NUM  (N),
      .PHASE(s % 2)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .d_ctrl(cctl[s]),
      .d_vals(cval[s]),
      .q_ctrl(cctl[s+1]),
      .q_vals(cval[s+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= cctl[N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= cctl[N].emit;
      m_tlast <= cctl[N].last;
      if (!cctl[N].emit) begin
        m_tdata <= '0;
      end else if (cctl[N].inner) begin
        m_tdata <= 24'(cval[N][MID]);
      end else begin
        m_tdata <= 24'(cctl[N].pass);
      end
    end
  end

endmodule

`default_nettype wire

FILE: test/cmf2d_checker.sv
`default_nettype none

module cmf2d_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [23:0]                      s_tdata,
  input  logic                             s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [23:0]                      m_tdata,
  input  logic                             m_tuser,
  input  logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [cmf2d_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cmf2d_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               pending,
  output int                               fails
);
  timeunit 1ns;
  timeprecision 1ps;
  import cmf2d_pkg::*;

  localparam int RING = 2 * DEF_MAX_HALF + 1;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct {
    logic   present;
    pixel_t px;
    logic   last;
  } median_result_t;

  median_result_t results_due[$];
  logic [23:0] pixel_rows[RING][DEF_MAX_WIDTH];
  logic [23:0] win[RING*RING];
  int unsigned row_in, col_in, out_idx;
  logic [1:0]  kern_half;
  logic [10:0] frame_w, frame_h;

  assign pending = results_due.size();

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic logic [7:0] chan_median(input int n, input int sh);
    int vals[RING*RING];
    int k, v;
    for (int i = 0; i < n; i++) begin
      v = (win[i] >> sh) & 8'hff;
      k = i;
      while (k > 0 && vals[k-1] > v) begin
        vals[k] = vals[k-1];
        k--;
      end
      vals[k] = v;
    end
    return vals[n/2];
  endfunction

  task automatic predict_pixel(input logic req, input logic [23:0] d);
    int unsigned h, w, ht, total, delay, avail, i, j, n;
    logic advance;
    median_result_t res;
    h = (kern_half > DEF_MAX_HALF) ? DEF_MAX_HALF : kern_half;
    w = clamp_dim(frame_w, DEF_MAX_WIDTH);
    ht = clamp_dim(frame_h, DEF_MAX_HEIGHT);
    total = w * ht;
    delay = h * w + h;
    avail = row_in * w + col_in;
    advance = 0;
    res = '{present: 0, px: '0, last: 0};
    if (avail < total) begin
      if (req != REQ_FLUSH) begin
        pixel_rows[row_in % RING][col_in] = d;
        advance = 1;
      end
    end else if (row_in < ht + RING) begin
      advance = 1;
    end
    if (advance) begin
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
    end
    avail = row_in * w + col_in;
    if (out_idx < total && (avail >= total || avail > out_idx + delay)) begin
      i = out_idx / w;
      j = out_idx % w;
      if (h > 0 && i >= h && i + h < ht && j >= h && j + h < w) begin
        n = 0;
        for (int x = i - h; x <= i + h; x++)
          for (int y = j - h; y <= j + h; y++) begin
            win[n] = pixel_rows[x % RING][y];
            n++;
          end
        res.px.b = chan_median(n, 0);
        res.px.g = chan_median(n, 8);
        res.px.r = chan_median(n, 16);
      end else begin
        res.px = pixel_rows[i % RING][j];
      end
      res.present = 1;
      out_idx++;
      if (out_idx >= total) begin
        res.last = 1;
        row_in = 0;
        col_in = 0;
        out_idx = 0;
      end
    end
    results_due = {results_due, res};
  endtask

  always @(posedge clk) begin
    median_result_t exp_res;
    pixel_t got;
    if (rst) begin
      results_due.delete();
      row_in = 0;
      col_in = 0;
      out_idx = 0;
      kern_half = 2'(RESET_HALF);
      frame_w = 11'(RESET_WIDTH);
      frame_h = 11'(RESET_HEIGHT);
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_HALF: kern_half = cfg_data[1:0];
          REG_WIDTH: frame_w = cfg_data;
          REG_HEIGHT: frame_h = cfg_data;
          default: ;
        endcase
        if (cfg_addr == REG_HALF || cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT) begin
          row_in = 0;
          col_in = 0;
          out_idx = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (results_due.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          exp_res = results_due.pop_front();
          if (m_tuser !== exp_res.present) begin
            $error("out_valid: expected %0d, got %0d", exp_res.present, m_tuser);
            fails++;
          end
          if (got.b !== exp_res.px.b) begin
            $error("blue_out: expected %0d, got %0d", exp_res.px.b, got.b);
            fails++;
          end
          if (got.g !== exp_res.px.g) begin
            $error("green_out: expected %0d, got %0d", exp_res.px.g, got.g);
            fails++;
          end
          if (got.r !== exp_res.px.r) begin
            $error("red_out: expected %0d, got %0d", exp_res.px.r, got.r);
            fails++;
          end
          if (m_tlast !== exp_res.last) begin
            $error("frame_last: expected %0d, got %0d", exp_res.last, m_tlast);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) predict_pixel(s_tuser, s_tdata);
    end
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cmf2d_pkg::*;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = (2 * DEF_MAX_HALF + 1) ** 2 + 12;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, s_tready, s_tuser = 0;
  logic [23:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0, m_tuser, m_tlast;
  logic [23:0] m_tdata;
  logic cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int pending, fails;
  int burst_left = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  logic hold_req = 0;
  logic [1:0] cur_half;
  logic [10:0] cur_w, cur_h;

  always #10 clk = ~clk;

  color_median_filter_2d_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_addr, .cfg_data
  );

  cmf2d_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_addr, .cfg_data, .pending, .fails
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int len, duty;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end
      len = $urandom_range(5, 80);
      duty = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(10, 90);
      repeat (len) begin
        m_tready <= ($urandom_range(1, 100) <= duty);
        @(posedge clk);
      end
    end
  end

  task automatic send(input logic req, input logic [23:0] d);
    if (burst_left == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 15);
    end
    s_tvalid <= 1;
    s_tuser <= req;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (a)
      REG_HALF: cur_half = v[1:0];
      REG_WIDTH: cur_w = v;
      REG_HEIGHT: cur_h = v;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] h, input logic [10:0] w, input logic [10:0] ht);
    wait_idle();
    write_reg(REG_HALF, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, ht);
  endtask

  function automatic int dim_of(input logic [10:0] v);
    if (v == 0) return 1;
    return (v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : v;
  endfunction

  function automatic logic [23:0] rand_px(input bit narrow);
    if (narrow) return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                        8'($urandom_range(0, 3))} * 24'h55;
    return 24'($urandom);
  endfunction

  // one frame; stop_at < total cuts it short
  task automatic run_frame(input int stop_at, input int noise_pct);
    int w, ht, total, delay, done_early, drain;
    bit narrow;
    w = dim_of(cur_w);
    ht = dim_of(cur_h);
    total = w * ht;
    delay = cur_half * w + cur_half;
    narrow = $urandom_range(0, 3) == 0;
    for (int k = 0; k < total && k < stop_at; k++) begin
      if ($urandom_range(1, 100) <= noise_pct) send(REQ_FLUSH, 24'($urandom));
      send(REQ_PIXEL, rand_px(narrow));
    end
    if (stop_at < total) return;
    done_early = ((total - 1 > delay) ? total - 1 - delay : 0) + 1;
    drain = total - done_early;
    for (int k = 0; k < drain; k++)
      send(($urandom_range(1, 100) <= 25) ? REQ_PIXEL : REQ_FLUSH, rand_px(narrow));
  endtask

  initial begin
    int frame_no;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, stray flush, pixels in drain, unused register
    write_reg(REG_UNUSED, 11'h7ff);
    configure(2'd1, 11'd4, 11'd3);
    send(REQ_FLUSH, 24'hffffff);
    for (int k = 0; k < 12; k++)
      send(REQ_PIXEL, (k % 2) ? 24'hffffff : 24'h000000);
    send(REQ_PIXEL, 24'h123456);
    send(REQ_FLUSH, 24'h0);
    send(REQ_FLUSH, 24'h0);
    send(REQ_FLUSH, 24'h0);
    send(REQ_FLUSH, 24'h0);
    configure(2'd0, 11'd0, 11'd0);
    send(REQ_PIXEL, 24'hff00ff);
    send(REQ_PIXEL, 24'h00ff00);
    configure(2'd3, 11'd7, 11'd7);
    hold_req = 1;
    run_frame(1 << 30, 0);
    configure(2'd3, 11'd1, 11'd2047);
    run_frame(40, 5);
    configure(2'd0, 11'd1024, 11'd1);
    run_frame(1 << 30, 0);
    configure(2'd3, 11'd6, 11'd9);
    run_frame(1 << 30, 10);

    frame_no = 0;
    while (items_sent < 1750) begin
      configure(2'($urandom_range(0, 3)), 11'($urandom_range(0, 12)),
                11'($urandom_range(0, 12)));
      if (frame_no == 3) hold_req = 1;
      if ($urandom_range(0, 6) == 0)
        run_frame($urandom_range(0, 60), 10);
      else
        run_frame(1 << 30, $urandom_range(0, 1) ? 0 : 15);
      frame_no++;
    end

    wait_idle();
    if (fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
